[hdl/bfa_pkg.sv]
// ============================================================================
// bfa_pkg - shared definitions of the 3x3 box mean filter
// Sizes, codes, the row store port structs and the reciprocal table used
// by the mean divider.
// ============================================================================
package bfa_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int PIX_W       = 8;
    localparam int DIM_W       = 11;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int NUM_SLOTS   = 3;
    localparam int SLOT_W      = 2;
    localparam int WORD_W      = NUM_SLOTS * PIX_W;
    localparam int COLSUM_W    = PIX_W + 2;
    localparam int SUM_W       = PIX_W + 4;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CNT_W       = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_LAST,
        ST_MULT,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  addr;
        logic [SLOT_W-1:0] slot;
        logic [PIX_W-1:0]  data;
    } ram_wr_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
    } ram_rd_t;

    // Clamp a configured dimension into 1..limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] limit);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > limit) begin
            r = limit;
        end
        return r;
    endfunction

    // Scaled reciprocal of the window size (rows times columns). Each value is
    // ceil(2^16 / count); for sums below 2304 the product shifted right by 16
    // is the exact floor quotient.
    function automatic logic [RECIP_W-1:0] mean_recip(input logic [1:0] nr,
                                                      input logic [1:0] nc);
        logic [CNT_W-1:0] cnt;
        logic [RECIP_W-1:0] r;
        cnt = CNT_W'(nr) * CNT_W'(nc);
        case (cnt)
            CNT_W'(2): r = RECIP_W'(32768);
            CNT_W'(3): r = RECIP_W'(21846);
            CNT_W'(4): r = RECIP_W'(16384);
            CNT_W'(6): r = RECIP_W'(10923);
            CNT_W'(9): r = RECIP_W'(7282);
            default:   r = RECIP_W'(65536);
        endcase
        return r;
    endfunction

endpackage

[hdl/box_filter_3x3_edge_avg_unit.sv]
// ============================================================================
// box_filter_3x3_edge_avg_unit - streaming 3x3 mean filter
// Raster-order 8-bit pixels in, floor mean of each in-bounds 3x3 window out.
// ============================================================================
// A request on the input channel is either a pixel (tuser = 0) or a flush
// (tuser = 1). Every output except those of the final row is released by the
// pixel that is its lower-right in-bounds neighbor, so one pixel can release
// up to two outputs; the final row is then released one output per flush.
// Pixels that arrive while the final row is still pending are dropped, and a
// flush with nothing pending produces nothing. Border outputs average over the
// 4 or 6 pixels inside the image; a one-column image averages over 1 to 3.
// Sequencing: a request that releases no output leaves the block idle. Each
// output released is computed over the nc columns of its window, nc being 1
// to 3: the row store has a single read port and returns one column of all
// three rows per cycle, followed by the reciprocal multiply and the result
// held on m_tvalid until accepted. A new request is taken only once all
// outputs of the previous one have been delivered. Writes of frame_width
// and frame_height take effect at once, restart the image and may be issued
// only while the block is idle. The row store needs no clearing after reset.
// ============================================================================
module box_filter_3x3_edge_avg_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfa_pkg::DIM_W-1:0]         cfg_data,
    // Input requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] pixel_in
    input  logic [0:0]                        s_tuser,   // [0] op
    // Results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] smoothed
    output logic                              m_tlast,   // row_end
    output logic [0:0]                        m_tuser    // [0] frame_end
);
    import bfa_pkg::*;

    // Configuration, stored already clamped to the legal range.
    logic [DIM_W-1:0]  width_reg,     width_next;
    logic [DIM_W-1:0]  height_reg,    height_next;

    // Position of the next pixel and of the next output; the slot is the row
    // number modulo three, i.e. the byte lane of that row in the store.
    logic [COL_W-1:0]  in_col_reg,    in_col_next;
    logic [ROW_W-1:0]  in_row_reg,    in_row_next;
    logic [SLOT_W-1:0] in_slot_reg,   in_slot_next;
    logic [COL_W-1:0]  out_col_reg,   out_col_next;
    logic [ROW_W-1:0]  out_row_reg,   out_row_next;
    logic [SLOT_W-1:0] out_slot_reg,  out_slot_next;
    logic              complete_reg,  complete_next;

    // Output sequencer.
    state_t            state_reg,     state_next;
    logic [1:0]        emit_left_reg, emit_left_next;
    logic [COL_W-1:0]  scan_col_reg,  scan_col_next;
    logic [COL_W-1:0]  scan_end_reg,  scan_end_next;
    logic              rd_pend_reg,   rd_pend_next;
    logic [SUM_W-1:0]  sum_reg,       sum_next;

    logic              s_accept, m_accept, cfg_accept;
    op_t               op_in;
    logic              take_pixel, take_flush;
    logic              in_col_last, in_row_last, out_col_last, out_row_last;
    logic [1:0]        pix_emits, new_emits;
    logic              win_up, win_dn, win_left, win_right;
    logic [1:0]        nr, nc;
    logic [SLOT_W-1:0] slot_up, slot_dn;
    logic [COLSUM_W-1:0] col_sum;
    logic              div_load;
    logic [PIX_W-1:0]  quot;

    ram_wr_t           ram_wr;
    ram_rd_t           ram_rd;
    logic [WORD_W-1:0] ram_rd_data;

    function automatic logic [PIX_W-1:0] lane(input logic [WORD_W-1:0] word,
                                              input logic [SLOT_W-1:0] slot);
        logic [PIX_W-1:0] b;
        case (slot)
            SLOT_W'(1): b = word[1*PIX_W +: PIX_W];
            SLOT_W'(2): b = word[2*PIX_W +: PIX_W];
            default:    b = word[0 +: PIX_W];
        endcase
        return b;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    assign s_accept   = s_tvalid && s_tready;
    assign m_accept   = m_tvalid && m_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign op_in      = op_t'(s_tuser[0]);

    // Pixels are dropped once the whole image is in; flushes count only then.
    assign take_pixel = s_accept && (op_in == OP_PIXEL) && !complete_reg;
    assign take_flush = s_accept && (op_in == OP_FLUSH) && complete_reg;

    assign in_col_last  = (DIM_W'(in_col_reg) + DIM_W'(1)) >= width_reg;
    assign in_row_last  = (DIM_W'(in_row_reg) + DIM_W'(1)) >= height_reg;
    assign out_col_last = (DIM_W'(out_col_reg) + DIM_W'(1)) >= width_reg;
    assign out_row_last = (DIM_W'(out_row_reg) + DIM_W'(1)) >= height_reg;

    // A pixel past the first row completes the window to its upper left, and
    // at the end of a row also the window directly above it.
    assign pix_emits = {1'b0, (in_row_reg != '0) && (in_col_reg != '0)}
                     + {1'b0, (in_row_reg != '0) && in_col_last};
    assign new_emits = take_flush ? 2'd1 : (take_pixel ? pix_emits : 2'd0);

    // Window of the output at (out_row, out_col), clipped to the image.
    assign win_up    = (out_row_reg != '0);
    assign win_dn    = !out_row_last;
    assign win_left  = (out_col_reg != '0);
    assign win_right = !out_col_last;
    assign nr        = 2'd1 + {1'b0, win_up} + {1'b0, win_dn};
    assign nc        = 2'd1 + {1'b0, win_left} + {1'b0, win_right};
    assign slot_up   = (out_slot_reg == '0) ? SLOT_W'(NUM_SLOTS - 1)
                                            : out_slot_reg - SLOT_W'(1);
    assign slot_dn   = slot_inc(out_slot_reg);

    // Sum of one store word over the rows that lie inside the window.
    assign col_sum = COLSUM_W'(lane(ram_rd_data, out_slot_reg))
                   + (win_up ? COLSUM_W'(lane(ram_rd_data, slot_up)) : '0)
                   + (win_dn ? COLSUM_W'(lane(ram_rd_data, slot_dn)) : '0);

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (new_emits != 2'd0)) begin
                    state_next = ST_START;
                end
            end
            ST_START: state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_col_reg == scan_end_reg) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:  state_next = ST_MULT;
            ST_MULT:  state_next = ST_SEND;
            ST_SEND: begin
                if (m_accept) begin
                    state_next = (emit_left_reg == 2'd1) ? ST_IDLE : ST_START;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------------
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        div_load = 1'b0;
        ram_rd   = '{en: 1'b0, addr: scan_col_reg};
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_SCAN:  ram_rd.en = 1'b1;
            ST_MULT:  div_load  = 1'b1;
            ST_SEND:  m_tvalid  = 1'b1;
            default: begin
            end
        endcase
    end

    // The pixel is written at the edge that accepts it. Reads of the window
    // start in ST_SCAN after ST_START, so the store never sees a read and a write
    // of the same word in one cycle and no forwarding is needed.
    always_comb begin
        ram_wr.en   = take_pixel;
        ram_wr.addr = in_col_reg;
        ram_wr.slot = in_slot_reg;
        ram_wr.data = s_tdata[PIX_W-1:0];
    end

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // Next values of counters and datapath registers
    // ------------------------------------------------------------------------
    always_comb begin
        width_next     = width_reg;
        height_next    = height_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        in_slot_next   = in_slot_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_slot_next  = out_slot_reg;
        complete_next  = complete_reg;
        emit_left_next = emit_left_reg;
        scan_col_next  = scan_col_reg;
        scan_end_next  = scan_end_reg;
        sum_next       = sum_reg;
        rd_pend_next   = (state_reg == ST_SCAN);

        if (state_reg == ST_IDLE) begin
            emit_left_next = new_emits;
        end

        // Store the pixel position advance.
        if (take_pixel) begin
            if (in_col_last) begin
                in_col_next = '0;
                if (in_row_last) begin
                    complete_next = 1'b1;
                end else begin
                    in_row_next  = in_row_reg + ROW_W'(1);
                    in_slot_next = slot_inc(in_slot_reg);
                end
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end

        // Set up the column scan of the next window.
        if (state_reg == ST_START) begin
            scan_col_next = win_left ? out_col_reg - COL_W'(1) : out_col_reg;
            scan_end_next = win_right ? out_col_reg + COL_W'(1) : out_col_reg;
            sum_next      = '0;
        end

        if ((state_reg == ST_SCAN) && (scan_col_reg != scan_end_reg)) begin
            scan_col_next = scan_col_reg + COL_W'(1);
        end

        // Read data arrives in the cycle after its address.
        if (rd_pend_reg) begin
            sum_next = sum_reg + SUM_W'(col_sum);
        end

        // Delivered output: move to the next position; the last output of
        // the image starts a new one.
        if ((state_reg == ST_SEND) && m_accept) begin
            emit_left_next = emit_left_reg - 2'd1;
            if (out_col_last) begin
                out_col_next = '0;
                if (out_row_last) begin
                    out_row_next  = '0;
                    out_slot_next = '0;
                    in_col_next   = '0;
                    in_row_next   = '0;
                    in_slot_next  = '0;
                    complete_next = 1'b0;
                end else begin
                    out_row_next  = out_row_reg + ROW_W'(1);
                    out_slot_next = slot_inc(out_slot_reg);
                end
            end else begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end

        // A configuration write restarts the image.
        if (cfg_accept) begin
            case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_next  = clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
                CFG_FRAME_HEIGHT: height_next = clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
                default: begin
                end
            endcase
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
            complete_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= DIM_W'(1);
            height_reg    <= DIM_W'(1);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            complete_reg  <= 1'b0;
            state_reg     <= ST_IDLE;
            emit_left_reg <= 2'd0;
            rd_pend_reg   <= 1'b0;
        end else begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_slot_reg   <= in_slot_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_slot_reg  <= out_slot_next;
            complete_reg  <= complete_next;
            state_reg     <= state_next;
            emit_left_reg <= emit_left_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_col_reg <= scan_col_next;
        scan_end_reg <= scan_end_next;
        sum_reg      <= sum_next;
    end

    // ------------------------------------------------------------------------
    // Row store and divider
    // ------------------------------------------------------------------------
    bfa_row_ram u_row_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

    bfa_mean_div u_mean_div (
        .aclk (aclk),
        .load (div_load),
        .sum  (sum_reg),
        .nr   (nr),
        .nc   (nc),
        .quot (quot)
    );

    assign m_tdata    = quot;
    assign m_tlast    = out_col_last;
    assign m_tuser[0] = out_col_last && out_row_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_one_side_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is offered");

    a_busy_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (emit_left_reg != 2'd0))
        else $error("sequencer busy with no output owed");

    a_frame_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_accept && m_tuser[0]) |=> (!complete_reg && (out_row_reg == '0)))
        else $error("image did not restart after its last output");

    a_complete_at_row_start: assert property (@(posedge aclk) disable iff (!aresetn)
        complete_reg |-> (in_col_reg == '0))
        else $error("image complete with a partial input row");

    a_out_inside_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (DIM_W'(out_col_reg) < width_reg) && (DIM_W'(out_row_reg) < height_reg))
        else $error("output position outside the frame");

endmodule

[hdl/bfa_row_ram.sv]
// ============================================================================
// bfa_row_ram - three-row pixel store
// One word per column holds that column's pixel of each of the three rows
// kept; a write updates one byte lane, a read returns the word registered,
// in the cycle after its address.
// ============================================================================
module bfa_row_ram (
    input  logic                     aclk,
    input  bfa_pkg::ram_wr_t         wr,
    input  bfa_pkg::ram_rd_t         rd,
    output logic [bfa_pkg::WORD_W-1:0] rd_data
);
    import bfa_pkg::*;

    logic [WORD_W-1:0] mem [MAX_WIDTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (wr.slot == SLOT_W'(i)) begin
                    mem[wr.addr][i*PIX_W +: PIX_W] <= wr.data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/bfa_mean_div.sv]
// ============================================================================
// bfa_mean_div - window sum to floor mean
// Multiplies the sum by the reciprocal of the window size and keeps the
// product in a register; the quotient is its upper bits.
// ============================================================================
module bfa_mean_div (
    input  logic                       aclk,
    input  logic                       load,
    input  logic [bfa_pkg::SUM_W-1:0]  sum,
    input  logic [1:0]                 nr,
    input  logic [1:0]                 nc,
    output logic [bfa_pkg::PIX_W-1:0]  quot
);
    import bfa_pkg::*;

    logic [PROD_W-1:0] product_reg;
    logic [PROD_W-1:0] product_next;

    assign product_next = PROD_W'(sum) * PROD_W'(mean_recip(nr, nc));

    always_ff @(posedge aclk) begin
        if (load) begin
            product_reg <= product_next;
        end
    end

    assign quot = product_reg[RECIP_SHIFT +: PIX_W];

endmodule
